// ===== rtl/core/euler_to_quaternion_assert.svh =====
// assertion macros used by the checker file
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// condition must hold at every edge out of reset
`define EQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define EQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/euq_pkg.sv =====
// ----------------------------------------------------------------------------
// euq_pkg
// shared constants and arithmetic helpers for the euler to quaternion block
// ----------------------------------------------------------------------------
package euq_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int ANGLE_W           = 16;
    localparam int QUAT_W            = 16;
    localparam int XY_W              = 33;
    localparam int Z_W               = 32;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [XY_W-1:0]    CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [QUAT_W+1:0]  Q_ONE_OUT   = 18'sd16384;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  z_t;

    // arctangent of 2^-i in units of 2^-29 rad
    function automatic z_t atan_q29(input int idx);
        z_t r;
        unique case (idx)
            0:  r = 32'sd421657428;
            1:  r = 32'sd248918915;
            2:  r = 32'sd131521918;
            3:  r = 32'sd66762579;
            4:  r = 32'sd33510843;
            5:  r = 32'sd16771758;
            6:  r = 32'sd8387925;
            7:  r = 32'sd4194219;
            8:  r = 32'sd2097141;
            9:  r = 32'sd1048575;
            10: r = 32'sd524288;
            11: r = 32'sd262144;
            12: r = 32'sd131072;
            13: r = 32'sd65536;
            14: r = 32'sd32768;
            15: r = 32'sd16384;
            16: r = 32'sd8192;
            17: r = 32'sd4096;
            18: r = 32'sd2048;
            19: r = 32'sd1024;
            20: r = 32'sd512;
            21: r = 32'sd256;
            22: r = 32'sd128;
            23: r = 32'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q2.30 product, rounded half up
    function automatic xy_t mul30(input xy_t a, input xy_t b);
        logic signed [2*XY_W:0] prod;
        logic signed [2*XY_W:0] shifted;
        prod    = 67'(a) * 67'(b);
        prod    = prod + (67'sd1 <<< 29);
        shifted = prod >>> 30;
        return shifted[XY_W-1:0];
    endfunction

    // q.30 sum to q1.14 with rounding and saturation
    function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [XY_W:0] v);
        logic signed [XY_W:0]   rnd;
        logic signed [QUAT_W+1:0] r;
        rnd = v + 34'sd32768;
        r   = 18'(rnd >>> 16);
        if (r > Q_ONE_OUT)
        begin
            r = Q_ONE_OUT;
        end
        else if (r < -Q_ONE_OUT)
        begin
            r = -Q_ONE_OUT;
        end
        return r[QUAT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/euq_if.sv =====
// ----------------------------------------------------------------------------
// euq_if
// request channels for angle requests and quaternion results
// ----------------------------------------------------------------------------
interface euq_angle_if import euq_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface euq_quat_if import euq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/core/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion
// zyx euler angles to unit quaternion through three pipelined cordic lanes
// ----------------------------------------------------------------------------
//  channel   dir   payload                              format
//  angles    in    roll_angle pitch_angle yaw_angle     q3.13 rad
//  quat      out   quat_w quat_x quat_y quat_z          q1.14
//
//  one request per cycle unless the output stalls; min(CORDIC_STAGES,24) + 4
//  register stages: the input register, one register per cordic iteration,
//  two product stages and the output stage
//  reset clears only the valid bits
//  a stalled output freezes the whole pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
module euler_to_quaternion
    import euq_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    euq_angle_if.sink       angles,
    euq_quat_if.source      quat
);

    localparam int N     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int DEPTH = N + 4;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    // cordic lane registers: index 0 roll, 1 pitch, 2 yaw
    xy_t x_reg [0:N][0:2];
    xy_t y_reg [0:N][0:2];
    z_t  z_reg [0:N][0:2];

    xy_t p_reg [0:3];
    xy_t t_reg [0:7];

    logic signed [QUAT_W-1:0] w_reg, qx_reg, qy_reg, qz_reg;

    logic signed [ANGLE_W-1:0] ang [0:2];

    assign adv          = !vld_reg[DEPTH-1] || quat.ready;
    assign angles.ready = adv;

    assign ang[0] = angles.roll_angle;
    assign ang[1] = angles.pitch_angle;
    assign ang[2] = angles.yaw_angle;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], angles.valid};
        end
    end

    // input stage: clamp and form the half angle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic signed [ANGLE_W-1:0] a;
                a = ang[l];
                if (a > ANGLE_LIMIT)
                begin
                    a = ANGLE_LIMIT;
                end
                else if (a < -ANGLE_LIMIT)
                begin
                    a = -ANGLE_LIMIT;
                end
                z_reg[0][l] <= Z_W'(a) <<< 15;
                x_reg[0][l] <= CORDIC_GAIN;
                y_reg[0][l] <= '0;
            end
        end
    end

    // one cordic iteration per stage
    for (genvar g = 0; g < N; g++)
    begin : g_cordic
        xy_t x_next [0:2];
        xy_t y_next [0:2];
        z_t  z_next [0:2];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (!z_reg[g][l][Z_W-1])
                begin
                    x_next[l] = x_reg[g][l] - (y_reg[g][l] >>> g);
                    y_next[l] = y_reg[g][l] + (x_reg[g][l] >>> g);
                    z_next[l] = z_reg[g][l] - atan_q29(g);
                end
                else
                begin
                    x_next[l] = x_reg[g][l] + (y_reg[g][l] >>> g);
                    y_next[l] = y_reg[g][l] - (x_reg[g][l] >>> g);
                    z_next[l] = z_reg[g][l] + atan_q29(g);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    x_reg[g+1][l] <= x_next[l];
                    y_reg[g+1][l] <= y_next[l];
                    z_reg[g+1][l] <= z_next[l];
                end
            end
        end
    end

    // pair products: cr*cp, sr*sp, sr*cp, cr*sp
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= mul30(x_reg[N][0], x_reg[N][1]);
            p_reg[1] <= mul30(y_reg[N][0], y_reg[N][1]);
            p_reg[2] <= mul30(y_reg[N][0], x_reg[N][1]);
            p_reg[3] <= mul30(x_reg[N][0], y_reg[N][1]);
        end
    end

    // triple products with the yaw terms, delayed one stage alongside
    xy_t cy_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy_reg   <= x_reg[N][2];
            sy_reg   <= y_reg[N][2];
            t_reg[0] <= mul30(p_reg[0], cy_reg);
            t_reg[1] <= mul30(p_reg[1], sy_reg);
            t_reg[2] <= mul30(p_reg[2], cy_reg);
            t_reg[3] <= mul30(p_reg[3], sy_reg);
            t_reg[4] <= mul30(p_reg[3], cy_reg);
            t_reg[5] <= mul30(p_reg[2], sy_reg);
            t_reg[6] <= mul30(p_reg[0], sy_reg);
            t_reg[7] <= mul30(p_reg[1], cy_reg);
        end
    end

    // combine, round and saturate
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg  <= to_out(34'(t_reg[0]) + 34'(t_reg[1]));
            qx_reg <= to_out(34'(t_reg[2]) - 34'(t_reg[3]));
            qy_reg <= to_out(34'(t_reg[4]) + 34'(t_reg[5]));
            qz_reg <= to_out(34'(t_reg[6]) - 34'(t_reg[7]));
        end
    end

    assign quat.valid  = vld_reg[DEPTH-1];
    assign quat.quat_w = w_reg;
    assign quat.quat_x = qx_reg;
    assign quat.quat_y = qy_reg;
    assign quat.quat_z = qz_reg;

endmodule

// ===== rtl/core/euq_checker.sv =====
// ----------------------------------------------------------------------------
// euq_checker
// port level checks on the euler to quaternion block
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module euq_checker
    import euq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [QUAT_W-1:0] quat_w,
    input logic signed [QUAT_W-1:0] quat_x
);

    // an empty output side never blocks requests
    `EQ_ASSERT_ALWAYS(a_ready_when_empty, out_valid || in_ready, "input stalled while empty")

    // a stalled result stays
    `EQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quat_w), "dropped")

    // w and x components stay within one
    `EQ_ASSERT_ALWAYS(a_w_range, !out_valid || (quat_w <= Q_ONE_OUT && quat_w >= -Q_ONE_OUT), "w")

    `EQ_ASSERT_ALWAYS(a_x_range, !out_valid || (quat_x <= Q_ONE_OUT && quat_x >= -Q_ONE_OUT), "x")

endmodule

bind euler_to_quaternion euq_checker u_euq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (angles.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .quat_w    (quat.quat_w),
    .quat_x    (quat.quat_x)
);

// ===== tb/euler_to_quaternion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// drives roll, pitch and yaw angle requests into the cordic pipeline and
// checks every quaternion result against a bit exact fixed point model,
// with random gaps on both channels, a long output stall and a full drain
// ----------------------------------------------------------------------------

// expected quaternion results, oldest first
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    localparam int STAGES    = euq_pkg::CORDIC_STAGES_DEF;
    localparam longint LIMIT = 25736;
    localparam longint GAIN  = 652032874;

    quat_t  quat_queue[$];
    int     mismatches;
    int     matched;

    // atan(2^-i) in units of 2^-29 rad
    longint atan_lut[24] = '{
        421657428, 248918915, 131521918, 66762579,
        33510843, 16771758, 8387925, 4194219,
        2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024,
        512, 256, 128, 64
    };

    function new();
        mismatches = 0;
        matched    = 0;
    endfunction

    // half angle cosine and sine in q2.30
    function void half_cos_sin(input logic signed [15:0] ang,
                               output longint c, output longint s);
        longint a, zr, xr, yr, nx;
        a = ang;
        if (a > LIMIT) a = LIMIT;
        if (a < -LIMIT) a = -LIMIT;
        zr = a * 32768;
        xr = GAIN;
        yr = 0;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            if (zr >= 0)
            begin
                nx = xr - (yr >>> i);
                yr = yr + (xr >>> i);
                zr = zr - atan_lut[i];
            end
            else
            begin
                nx = xr + (yr >>> i);
                yr = yr - (xr >>> i);
                zr = zr + atan_lut[i];
            end
            xr = nx;
        end
        c = xr;
        s = yr;
    endfunction

    function longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint qmul3(input longint a, input longint b, input longint c);
        return qmul(qmul(a, b), c);
    endfunction

    // q.30 sum to saturated q1.14
    function logic signed [15:0] to_q14(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function quat_t quat_from_euler(input logic signed [15:0] roll,
                                    input logic signed [15:0] pitch,
                                    input logic signed [15:0] yaw);
        longint cr, sr, cp, sp, cy, sy;
        quat_t q;
        half_cos_sin(roll, cr, sr);
        half_cos_sin(pitch, cp, sp);
        half_cos_sin(yaw, cy, sy);
        q.w = to_q14(qmul3(cr, cp, cy) + qmul3(sr, sp, sy));
        q.x = to_q14(qmul3(sr, cp, cy) - qmul3(cr, sp, sy));
        q.y = to_q14(qmul3(cr, sp, cy) + qmul3(sr, cp, sy));
        q.z = to_q14(qmul3(cr, cp, sy) - qmul3(sr, sp, cy));
        return q;
    endfunction

    function void note_request(input logic signed [15:0] roll,
                               input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw);
        quat_queue.push_back(quat_from_euler(roll, pitch, yaw));
    endfunction

    task report(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_result(input logic signed [15:0] w, input logic signed [15:0] x,
                      input logic signed [15:0] y, input logic signed [15:0] z);
        quat_t e;
        if (quat_queue.size() == 0)
        begin
            report("results beyond requests", matched + 1, matched);
            return;
        end
        e = quat_queue.pop_front();
        if (w !== e.w) report("quat_w", w, e.w);
        if (x !== e.x) report("quat_x", x, e.x);
        if (y !== e.y) report("quat_y", y, e.y);
        if (z !== e.z) report("quat_z", z, e.z);
        matched++;
    endtask

    function int pending();
        return quat_queue.size();
    endfunction
endclass

module euler_to_quaternion_tb;
    import euq_pkg::*;

    logic clk;
    logic rst_n;

    euq_angle_if angle_ch ();
    euq_quat_if  quat_ch ();

    euler_to_quaternion uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angle_ch),
        .quat   (quat_ch)
    );

    quat_scoreboard sb = new();

    int hold_requests = 0;
    int holds_served  = 0;
    int sent          = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // initial drive
    initial
    begin
        rst_n               = 1'b0;
        angle_ch.valid      = 1'b0;
        angle_ch.roll_angle = '0;
        angle_ch.pitch_angle= '0;
        angle_ch.yaw_angle  = '0;
        quat_ch.ready       = 1'b0;
    end

    // watch both channels
    always @(posedge clk)
    begin
        if (rst_n && angle_ch.valid && angle_ch.ready)
        begin
            sb.note_request(angle_ch.roll_angle, angle_ch.pitch_angle, angle_ch.yaw_angle);
        end
        if (rst_n && quat_ch.valid && quat_ch.ready)
        begin
            sb.check_result(quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z);
        end
    end

    // result receiver with random stalls, quiet stretches and long hold-offs
    int stall_left = 0;
    int quiet_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quat_ch.ready <= 1'b0;
        end
        else if (holds_served < hold_requests)
        begin
            holds_served++;
            stall_left = 300;
            quat_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            quat_ch.ready <= 1'b0;
        end
        else if (quiet_left > 0)
        begin
            quiet_left--;
            quat_ch.ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       quiet_left = $urandom_range(20, 80);
                1:       stall_left = $urandom_range(10, 40);
                2, 3, 4: stall_left = $urandom_range(0, 3);
                default: stall_left = 0;
            endcase
            quat_ch.ready <= (stall_left == 0);
        end
    end

    // sender gap length, mostly short, a few long
    function int pick_gap();
        case ($urandom_range(0, 19))
            0:             return $urandom_range(10, 40);
            1, 2, 3, 4, 5: return $urandom_range(1, 3);
            default:       return 0;
        endcase
    endfunction

    // offer one request and wait for it to be taken
    task send_request(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                      input logic signed [15:0] yaw, input int gap);
        angle_ch.valid       <= 1'b1;
        angle_ch.roll_angle  <= roll;
        angle_ch.pitch_angle <= pitch;
        angle_ch.yaw_angle   <= yaw;
        @(posedge clk);
        while (!angle_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
        if (gap > 0)
        begin
            angle_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every expected result has come back
    task drain();
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // angle mostly inside +-pi, some over the full word, some at the edges
    function logic signed [15:0] pick_angle();
        int v;
        case ($urandom_range(0, 19))
            0, 1, 2: v = $urandom_range(0, 65535) - 32768;
            3:       v = ($urandom_range(0, 1) != 0) ? 25736 : -25736;
            4:       v = $urandom_range(0, 1) ? $urandom_range(25737, 32767)
                                              : -$urandom_range(25737, 32768);
            default: v = $urandom_range(0, 51472) - 25736;
        endcase
        return v[15:0];
    endfunction

    localparam logic signed [15:0] HALF_PI = 16'sd12868;
    logic signed [15:0] corner [8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
                                       -16'sd32768, HALF_PI, -HALF_PI, 16'sd1};

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, +-pi, beyond +-pi, +-pi/2, one lsb, mixed corners
        for (int i = 0; i < 8; i++)
        begin
            send_request(corner[i], 16'sd0, 16'sd0, 0);
            send_request(16'sd0, corner[i], 16'sd0, 0);
            send_request(16'sd0, 16'sd0, corner[i], pick_gap());
        end
        send_request(16'sd25736, 16'sd25736, 16'sd25736, 0);

        // random stream; one long output hold-off and one drain along the way
        for (int n = 0; n < 600; n++)
        begin
            if (n == 150)
            begin
                hold_requests++;
            end
            if (n == 400)
            begin
                angle_ch.valid <= 1'b0;
                drain();
                repeat (30) @(posedge clk);
            end
            send_request(pick_angle(), pick_angle(), pick_angle(), pick_gap());
        end
        angle_ch.valid <= 1'b0;

        drain();
        repeat (40) @(posedge clk);
        $display("sent %0d angle requests, %0d quaternion results checked", sent, sb.matched);
        $display("covered +-pi limits, out of range angles, long stall and drain");
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("PASS euler_to_quaternion");
        end
        else
        begin
            $display("FAIL euler_to_quaternion");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("FAIL euler_to_quaternion");
        $finish;
    end
endmodule

// ===== euler_to_quaternion.f =====
+incdir+rtl/core
rtl/core/euq_pkg.sv
rtl/core/euq_if.sv
rtl/core/euler_to_quaternion.sv
rtl/core/euq_checker.sv
tb/euler_to_quaternion_tb.sv
